### design/barometer_temperature_compensation_assert.svh
// Assertion macros shared by the barometer compensation modules.
// Each macro expects signals named clk and rst_n in the module that uses it.
// Defining NO_ASSERTIONS turns every macro into an empty body.
`ifndef BAROMETER_TEMPERATURE_COMPENSATION_ASSERT_SVH
`define BAROMETER_TEMPERATURE_COMPENSATION_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define BCOMP_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define BCOMP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define BCOMP_ASSERT_IMPLY(label, ante, cons, msg)

`define BCOMP_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

### design/bcomp_pkg.sv
// Types and constants for the barometer compensation pipeline.
// Used by bcomp_temp_stages and barometer_temperature_compensation; no dependencies.
package bcomp_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_C1 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_C2 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_C3 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_C4 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_C5 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_C6 = 3'd5;

    localparam int RAW_W = 24;
    localparam int DT_W = 25;
    localparam int TEMP_W = 20;
    localparam int OFF_W = 44;
    localparam int SENS_W = 40;
    localparam int SQ_W = 36;
    localparam int T2_W = 18;

    localparam logic signed [TEMP_W-1:0] T_REF = 20'sd2000;
    localparam logic signed [TEMP_W-1:0] T_COLD = -20'sd1500;

    typedef struct packed {
        logic [RAW_W-1:0] raw_pressure;
        logic [RAW_W-1:0] raw_temperature;
    } in_t;

    typedef struct packed {
        logic signed [31:0] temperature_centi;
        logic signed [31:0] pressure_pa;
    } out_t;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] pressure_sensitivity_coeff;
        logic [CFG_DATA_W-1:0] pressure_offset_coeff;
        logic [CFG_DATA_W-1:0] sensitivity_temp_coeff;
        logic [CFG_DATA_W-1:0] offset_temp_coeff;
        logic [CFG_DATA_W-1:0] reference_temp_coeff;
        logic [CFG_DATA_W-1:0] temperature_slope_coeff;
    } cal_t;

endpackage

### design/bcomp_temp_stages.sv
// Front five pipeline stages: temperature delta, first-order terms and second-order
// corrections. Depends on bcomp_pkg and the shared assertion macro header.
`include "barometer_temperature_compensation_assert.svh"

module bcomp_temp_stages (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                advance,
    input  logic                                in_valid,
    input  bcomp_pkg::in_t                      in_data,
    input  bcomp_pkg::cal_t                     cal,
    output logic                                out_valid,
    output logic signed [bcomp_pkg::TEMP_W-1:0] out_temp,
    output logic signed [bcomp_pkg::OFF_W-1:0]  out_off,
    output logic signed [bcomp_pkg::SENS_W-1:0] out_sens,
    output logic [bcomp_pkg::RAW_W-1:0]         out_d1
);
    import bcomp_pkg::*;

    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, s5_valid_reg;

    logic signed [DT_W-1:0] s1_dt_reg, s1_dt_next;
    logic [RAW_W-1:0]       s1_d1_reg;

    logic signed [41:0]     s2_p6_reg, s2_p4_reg, s2_p3_reg;
    logic signed [41:0]     s2_p6_next, s2_p4_next, s2_p3_next;
    logic signed [49:0]     s2_pdd_reg, s2_pdd_next;
    logic [RAW_W-1:0]       s2_d1_reg;

    logic signed [41:0]       p6_adj, p4_adj, p3_adj;
    logic signed [TEMP_W-1:0] s3_temp1_reg, s3_temp1_next;
    logic signed [OFF_W-1:0]  s3_off1_reg, s3_off1_next;
    logic signed [SENS_W-1:0] s3_sens1_reg, s3_sens1_next;
    logic [T2_W-1:0]          s3_t2_reg;
    logic [RAW_W-1:0]         s3_d1_reg;

    logic signed [TEMP_W-1:0] a_val, b_val;
    logic signed [39:0]       sq_a, sq_b;
    logic [SQ_W-1:0]          s4_a2_reg, s4_b2_reg;
    logic                     s4_below_reg, s4_cold_reg;
    logic signed [TEMP_W-1:0] s4_temp1_reg;
    logic signed [OFF_W-1:0]  s4_off1_reg;
    logic signed [SENS_W-1:0] s4_sens1_reg;
    logic [T2_W-1:0]          s4_t2_reg;
    logic [RAW_W-1:0]         s4_d1_reg;

    logic [OFF_W-1:0]         a2_off, b2_off, off2;
    logic [SENS_W-1:0]        a2_sens, b2_sens, sens2;
    logic signed [TEMP_W-1:0] s5_temp_reg, s5_temp_next;
    logic signed [OFF_W-1:0]  s5_off_reg, s5_off_next;
    logic signed [SENS_W-1:0] s5_sens_reg, s5_sens_next;
    logic [RAW_W-1:0]         s5_d1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
        end
    end

    always_comb
    begin
        s1_dt_next = $signed({1'b0, in_data.raw_temperature})
                   - $signed({1'b0, cal.reference_temp_coeff, 8'h00});
    end

    always_comb
    begin
        s2_p6_next  = s1_dt_reg * $signed({1'b0, cal.temperature_slope_coeff});
        s2_p4_next  = s1_dt_reg * $signed({1'b0, cal.offset_temp_coeff});
        s2_p3_next  = s1_dt_reg * $signed({1'b0, cal.sensitivity_temp_coeff});
        s2_pdd_next = s1_dt_reg * s1_dt_reg;
    end

    // Negative products get 2^k - 1 added before the arithmetic shift so the
    // quotient truncates toward zero.
    always_comb
    begin
        p6_adj = s2_p6_reg + $signed({19'b0, {23{s2_p6_reg[41]}}});
        p4_adj = s2_p4_reg + $signed({36'b0, {6{s2_p4_reg[41]}}});
        p3_adj = s2_p3_reg + $signed({35'b0, {7{s2_p3_reg[41]}}});
        s3_temp1_next = $signed({p6_adj[41], p6_adj[41:23]}) + T_REF;
        s3_off1_next  = $signed({11'b0, cal.pressure_offset_coeff, 17'b0})
                      + $signed({{8{p4_adj[41]}}, p4_adj[41:6]});
        s3_sens1_next = $signed({8'b0, cal.pressure_sensitivity_coeff, 16'b0})
                      + $signed({{5{p3_adj[41]}}, p3_adj[41:7]});
    end

    always_comb
    begin
        a_val = s3_temp1_reg - T_REF;
        b_val = s3_temp1_reg - T_COLD;
        sq_a  = a_val * a_val;
        sq_b  = b_val * b_val;
    end

    always_comb
    begin
        a2_off  = {{(OFF_W-SQ_W){1'b0}}, s4_a2_reg};
        b2_off  = {{(OFF_W-SQ_W){1'b0}}, s4_b2_reg};
        a2_sens = {{(SENS_W-SQ_W){1'b0}}, s4_a2_reg};
        b2_sens = {{(SENS_W-SQ_W){1'b0}}, s4_b2_reg};
        off2  = ((a2_off * OFF_W'(61)) >> 4)
              + (s4_cold_reg ? (b2_off * OFF_W'(15)) : '0);
        sens2 = (a2_sens << 1) + (s4_cold_reg ? (b2_sens << 3) : '0);
        s5_temp_next = s4_temp1_reg
                     - (s4_below_reg ? $signed({2'b0, s4_t2_reg}) : '0);
        s5_off_next  = s4_off1_reg - (s4_below_reg ? $signed(off2) : '0);
        s5_sens_next = s4_sens1_reg - (s4_below_reg ? $signed(sens2) : '0);
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_dt_reg    <= s1_dt_next;
            s1_d1_reg    <= in_data.raw_pressure;

            s2_p6_reg    <= s2_p6_next;
            s2_p4_reg    <= s2_p4_next;
            s2_p3_reg    <= s2_p3_next;
            s2_pdd_reg   <= s2_pdd_next;
            s2_d1_reg    <= s1_d1_reg;

            s3_temp1_reg <= s3_temp1_next;
            s3_off1_reg  <= s3_off1_next;
            s3_sens1_reg <= s3_sens1_next;
            s3_t2_reg    <= s2_pdd_reg[48:31];
            s3_d1_reg    <= s2_d1_reg;

            s4_a2_reg    <= sq_a[SQ_W-1:0];
            s4_b2_reg    <= sq_b[SQ_W-1:0];
            s4_below_reg <= s3_temp1_reg < T_REF;
            s4_cold_reg  <= s3_temp1_reg < T_COLD;
            s4_temp1_reg <= s3_temp1_reg;
            s4_off1_reg  <= s3_off1_reg;
            s4_sens1_reg <= s3_sens1_reg;
            s4_t2_reg    <= s3_t2_reg;
            s4_d1_reg    <= s3_d1_reg;

            s5_temp_reg  <= s5_temp_next;
            s5_off_reg   <= s5_off_next;
            s5_sens_reg  <= s5_sens_next;
            s5_d1_reg    <= s4_d1_reg;
        end
    end

    assign out_valid = s5_valid_reg;
    assign out_temp  = s5_temp_reg;
    assign out_off   = s5_off_reg;
    assign out_sens  = s5_sens_reg;
    assign out_d1    = s5_d1_reg;

    `BCOMP_ASSERT_NEXT(a_warm_keeps_temp, advance && s4_valid_reg && !s4_below_reg,
        s5_temp_reg == $past(s4_temp1_reg), "warm sample temperature was corrected")
    `BCOMP_ASSERT_IMPLY(a_cold_is_below, s4_valid_reg && s4_cold_reg, s4_below_reg,
        "cold flag set without below-reference flag")
    `BCOMP_ASSERT_NEXT(a_front_holds, !advance,
        $stable({s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, s5_valid_reg}),
        "front stages moved during a stall")

endmodule

### design/barometer_temperature_compensation.sv
// Top level of the barometer compensation pipeline: calibration registers,
// pressure stages and output register. Depends on bcomp_pkg and bcomp_temp_stages.
`include "barometer_temperature_compensation_assert.svh"

// The block takes one request of raw pressure and temperature readings per clock
// cycle while the output is not stalled and returns the compensated temperature
// and pressure: five stages build the temperature terms and the second-order
// corrections, two more form the 24 by 40 bit pressure product from two partial
// products, one applies the offset, and the last holds the result. A stalled
// output holds the whole pipeline in place. The user must write calibration words
// via the write port while no request is in flight; the block does not enforce it.
module barometer_temperature_compensation (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  bcomp_pkg::in_t                    in_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output bcomp_pkg::out_t                   out_data,
    input  logic                              cfg_we,
    input  logic [bcomp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bcomp_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import bcomp_pkg::*;

    cal_t cal_reg;
    logic advance;

    logic                     front_valid;
    logic signed [TEMP_W-1:0] front_temp;
    logic signed [OFF_W-1:0]  front_off;
    logic signed [SENS_W-1:0] front_sens;
    logic [RAW_W-1:0]         front_d1;

    logic                     s6_valid_reg, s7_valid_reg, s8_valid_reg;
    logic [43:0]              s6_pl_reg, s6_pl_next;
    logic signed [44:0]       s6_ph_reg, s6_ph_next;
    logic signed [TEMP_W-1:0] s6_temp_reg, s7_temp_reg, s8_temp_reg;
    logic signed [OFF_W-1:0]  s6_off_reg, s7_off_reg;
    logic signed [64:0]       s7_prod_reg, s7_prod_next;
    logic signed [64:0]       prod_adj;
    logic signed [44:0]       s8_q_reg, s8_q_next;
    logic signed [44:0]       q_adj;

    logic  out_valid_reg;
    out_t  out_data_reg, out_data_next;

    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_C1: cal_reg.pressure_sensitivity_coeff <= cfg_data;
                REG_C2: cal_reg.pressure_offset_coeff      <= cfg_data;
                REG_C3: cal_reg.sensitivity_temp_coeff     <= cfg_data;
                REG_C4: cal_reg.offset_temp_coeff          <= cfg_data;
                REG_C5: cal_reg.reference_temp_coeff       <= cfg_data;
                REG_C6: cal_reg.temperature_slope_coeff    <= cfg_data;
                default: ;
            endcase
        end
    end

    bcomp_temp_stages u_temp_stages (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (in_valid),
        .in_data   (in_data),
        .cal       (cal_reg),
        .out_valid (front_valid),
        .out_temp  (front_temp),
        .out_off   (front_off),
        .out_sens  (front_sens),
        .out_d1    (front_d1)
    );

    // The pressure quotient is bounded by the operand widths to 30 signed bits,
    // so it always lies inside the 32-bit result range.
    always_comb
    begin
        s6_pl_next   = front_d1 * front_sens[19:0];
        s6_ph_next   = $signed({1'b0, front_d1}) * $signed(front_sens[SENS_W-1:20]);
        s7_prod_next = $signed({s6_ph_reg, 20'b0}) + $signed({21'b0, s6_pl_reg});
        prod_adj     = s7_prod_reg + $signed({44'b0, {21{s7_prod_reg[64]}}});
        s8_q_next    = $signed({prod_adj[64], prod_adj[64:21]})
                     - $signed({s7_off_reg[OFF_W-1], s7_off_reg});
        q_adj        = s8_q_reg + $signed({30'b0, {15{s8_q_reg[44]}}});
        out_data_next.temperature_centi = {{(32-TEMP_W){s8_temp_reg[TEMP_W-1]}}, s8_temp_reg};
        out_data_next.pressure_pa       = {{2{q_adj[44]}}, q_adj[44:15]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s6_valid_reg  <= 1'b0;
            s7_valid_reg  <= 1'b0;
            s8_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s6_valid_reg  <= front_valid;
            s7_valid_reg  <= s6_valid_reg;
            s8_valid_reg  <= s7_valid_reg;
            out_valid_reg <= s8_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s6_pl_reg    <= s6_pl_next;
            s6_ph_reg    <= s6_ph_next;
            s6_temp_reg  <= front_temp;
            s6_off_reg   <= front_off;
            s7_prod_reg  <= s7_prod_next;
            s7_temp_reg  <= s6_temp_reg;
            s7_off_reg   <= s6_off_reg;
            s8_q_reg     <= s8_q_next;
            s8_temp_reg  <= s7_temp_reg;
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `BCOMP_ASSERT_NEXT(a_result_arrives, advance && s8_valid_reg, out_valid_reg,
        "last stage request did not reach the output")
    `BCOMP_ASSERT_NEXT(a_no_invented, advance && !s8_valid_reg, !out_valid_reg,
        "output request appeared from an empty stage")
    `BCOMP_ASSERT_NEXT(a_back_holds, !advance,
        $stable({s6_valid_reg, s7_valid_reg, s8_valid_reg}) && $stable(out_data_reg),
        "pressure stages moved during a stall")

endmodule
